/* rtl/lkv_pkg.sv */
// lkv_pkg: shared types and constants for the lru key/value cache
// used by the channel interfaces and the top level; depends on nothing
package lkv_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int KEY_W             = 32;
  localparam int VALUE_W           = 32;
  localparam int CAP_W             = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic                      command;
    logic signed [KEY_W-1:0]   lookup_key;
    logic        [VALUE_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] read_value;
  } rsp_t;

endpackage

/* rtl/lkv_req_if.sv */
// lkv_req_if: request channel (valid/ready plus one request item)
// depends on lkv_pkg for the item type
interface lkv_req_if;
  import lkv_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/lkv_rsp_if.sv */
// lkv_rsp_if: response channel (valid/ready plus one result item)
// depends on lkv_pkg for the item type
interface lkv_rsp_if;
  import lkv_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/lru_key_value_cache.sv */
// lru_key_value_cache: fully associative key/value cache with lru replacement
// depends on lkv_pkg, lkv_req_if and lkv_rsp_if
//
// Usage:
//   req  - get (command 0) or put (command 1) items with key and value
//   rsp  - one item per request: ok flag and read value
//   cfg  - cfg_we/cfg_wdata write the capacity in use (clamped to 1..DEPTH)
// An accepted item is held in the input register; the lookup and the table
// update then run in one pass into the result register, which offers the
// response. Throughput is one item per cycle while the receiver takes
// responses; the single pass of parallel key compare and rank update over
// all DEPTH entries sets this.
// A stalled receiver holds the result register; the input register keeps its
// item until the result register frees, so req.ready drops only when both are
// full. The table is updated only when a hit or a put moves to the result register.
// Reset empties the cache at once (valid bits and ranks cleared, occupancy 0)
// and sets the capacity to 16; keys and payloads are not cleared.
module lru_key_value_cache #(
  parameter int DEPTH         = lkv_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = lkv_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
  lkv_req_if.sink                   req,
  lkv_rsp_if.source                 rsp
);
  import lkv_pkg::*;

  localparam int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;

  // table
  logic [DEPTH-1:0]              entry_valid;
  logic [KEY_W-1:0]              entry_key     [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]      entry_payload [DEPTH];
  logic [RANK_W-1:0]             recency_rank  [DEPTH];
  logic [OCC_W-1:0]              occupancy;
  logic [CAP_W-1:0]              capacity;

  // input stage
  logic                          s1_valid;
  logic                          s1_cmd;
  logic [KEY_W-1:0]              s1_key;
  logic [PAYLOAD_WIDTH-1:0]      s1_val;

  // result stage
  logic                          o_valid;
  rsp_t                          o_data;

  logic                          out_adv;
  logic                          s1_fire;
  logic                          req_fire;

  logic [DEPTH-1:0]              hit_vec;
  logic [DEPTH-1:0]              lru_vec;
  logic [DEPTH-1:0]              free_vec;
  logic [DEPTH-1:0]              free_1h;
  logic [DEPTH-1:0]              tgt_1h;
  logic [DEPTH-1:0]              evict_vec;
  logic                          hit;
  logic [RANK_W-1:0]             hit_rank;
  logic [PAYLOAD_WIDTH-1:0]      hit_payload;
  logic [OCC_W-1:0]              tgt_rank;
  logic [OCC_W-1:0]              occ_m1;
  logic [CMP_W-1:0]              cap_c;
  logic                          cap_full;
  logic                          over_cap;
  logic                          insert;
  logic                          evict;
  logic                          do_update;
  logic [RANK_W-1:0]             rank_promo [DEPTH];
  logic [DEPTH-1:0]              valid_next;
  logic [RANK_W-1:0]             rank_next  [DEPTH];
  logic [OCC_W-1:0]              occupancy_next;
  logic [PAYLOAD_WIDTH+VALUE_W-1:0] wr_ext;
  logic [PAYLOAD_WIDTH+VALUE_W-1:0] rd_ext;
  rsp_t                          rsp_next;

  assign out_adv   = !o_valid || rsp.ready;
  assign s1_fire   = s1_valid && out_adv;
  assign req.ready = !s1_valid || out_adv;
  assign req_fire  = req.valid && req.ready;
  assign rsp.valid = o_valid;
  assign rsp.data  = o_data;

  // payload masked to PAYLOAD_WIDTH, returned zero-extended
  assign wr_ext = {{PAYLOAD_WIDTH{1'b0}}, req.data.write_value};

  // clamp capacity to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap_c = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      cap_c = CMP_W'(DEPTH);
    end else begin
      cap_c = CMP_W'(capacity);
    end
  end

  assign occ_m1   = occupancy - OCC_W'(1);
  assign cap_full = CMP_W'(occupancy) >= cap_c;
  assign over_cap = CMP_W'(occupancy) > cap_c;
  assign free_vec = ~entry_valid;
  assign free_1h  = free_vec & (~free_vec + DEPTH'(1));

  always_comb begin
    hit_rank    = '0;
    hit_payload = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_vec[i] = entry_valid[i] && (entry_key[i] == s1_key);
      lru_vec[i] = entry_valid[i] && (occupancy != '0) &&
                   (OCC_W'(recency_rank[i]) == occ_m1);
      if (hit_vec[i]) begin
        hit_rank    = hit_rank | recency_rank[i];
        hit_payload = hit_payload | entry_payload[i];
      end
    end
    hit = |hit_vec;
  end

  // pick the entry that becomes most recent; inserting is a promote from rank occupancy
  always_comb begin
    insert = 1'b0;
    if (hit) begin
      tgt_1h   = hit_vec;
      tgt_rank = OCC_W'(hit_rank);
    end else if (cap_full) begin
      tgt_1h   = lru_vec;
      tgt_rank = occ_m1;
    end else begin
      tgt_1h   = free_1h;
      tgt_rank = occupancy;
      insert   = s1_cmd;
    end
    evict     = s1_cmd && hit && over_cap;
    do_update = s1_fire && (hit || s1_cmd);
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (tgt_1h[i]) begin
        rank_promo[i] = '0;
      end else if (entry_valid[i] && (OCC_W'(recency_rank[i]) < tgt_rank)) begin
        rank_promo[i] = recency_rank[i] + RANK_W'(1);
      end else begin
        rank_promo[i] = recency_rank[i];
      end
      // least recent after the promote
      evict_vec[i] = entry_valid[i] && (OCC_W'(rank_promo[i]) == occ_m1);
      valid_next[i] = (entry_valid[i] || (insert && tgt_1h[i])) &&
                      !(evict && evict_vec[i]);
      rank_next[i] = (evict && evict_vec[i]) ? '0 : rank_promo[i];
    end
    occupancy_next = occupancy + OCC_W'(insert) - OCC_W'(evict);
  end

  always_comb begin
    rd_ext              = {{VALUE_W{1'b0}}, hit_payload};
    rsp_next.ok         = (s1_cmd == CMD_PUT) || hit;
    rsp_next.read_value = ((s1_cmd == CMD_GET) && hit) ? rd_ext[VALUE_W-1:0] : '0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      o_valid     <= 1'b0;
      capacity    <= CAP_RESET;
      entry_valid <= '0;
      occupancy   <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (out_adv) begin
        o_valid <= s1_valid;
      end
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (do_update) begin
        entry_valid <= valid_next;
        occupancy   <= occupancy_next;
        for (int i = 0; i < DEPTH; i++) begin
          recency_rank[i] <= rank_next[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_cmd <= req.data.command;
      s1_key <= req.data.lookup_key;
      s1_val <= wr_ext[PAYLOAD_WIDTH-1:0];
    end
    if (s1_fire) begin
      o_data <= rsp_next;
    end
    if (do_update && (s1_cmd == CMD_PUT)) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (tgt_1h[i]) begin
          entry_key[i]     <= s1_key;
          entry_payload[i] <= s1_val;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) == $countones(entry_valid))
    else $error("occupancy differs from number of valid entries");

  a_occ_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) <= DEPTH)
    else $error("occupancy above depth");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |-> (o_valid && !rsp.ready))
    else $error("input stage held while result register free");

  a_put_ok: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (s1_cmd == CMD_PUT)) |=> (o_valid && o_data.ok))
    else $error("put result without ok");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for lru_key_value_cache (gets, puts, lru eviction)
// depends on lkv_pkg, lkv_req_if, lkv_rsp_if and the cache rtl
module testbench;
  import lkv_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int KEY_POOL    = 24;
  localparam int PHASE_ITEMS = 160;
  localparam int PHASES      = 8;

  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               command;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               typed;
    rsp_t               want;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lkv_req_if req ();
  lkv_rsp_if rsp ();

  lru_key_value_cache dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  // shadow copy of the cache table
  bit                 live       [DEPTH];
  logic [KEY_W-1:0]   held_key   [DEPTH];
  logic [VALUE_W-1:0] held_value [DEPTH];
  int                 age_rank   [DEPTH];
  int                 occupancy;
  logic [CAP_W-1:0]   capacity;

  rsp_t             pending_results [$];
  dir_row_t         directed_rows   [$];
  logic [KEY_W-1:0] key_pool        [KEY_POOL];
  int               fault_count;
  int               send_idle_pct;
  int               recv_stall_pct;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // entries more recent than slot age by one, slot becomes most recent
  function automatic void make_recent(input int slot);
    int r;
    r = age_rank[slot];
    for (int i = 0; i < DEPTH; i++)
      if (live[i] && age_rank[i] < r) age_rank[i]++;
    age_rank[slot] = 0;
  endfunction

  function automatic int oldest_slot();
    for (int i = 0; i < DEPTH; i++)
      if (occupancy > 0 && live[i] && age_rank[i] == occupancy - 1) return i;
    return -1;
  endfunction

  function automatic rsp_t apply_request(input req_t item);
    rsp_t res;
    int   cap;
    int   hit;
    int   slot;
    res  = '0;
    hit  = -1;
    slot = -1;
    cap  = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : int'(capacity));
    for (int i = DEPTH - 1; i >= 0; i--)
      if (live[i] && held_key[i] == item.lookup_key) hit = i;
    if (item.command == CMD_GET) begin
      if (hit >= 0) begin
        make_recent(hit);
        res.ok         = 1'b1;
        res.read_value = held_value[hit];
      end
    end else if (hit >= 0) begin
      held_value[hit] = item.write_value;
      make_recent(hit);
      // capacity lowered below occupancy: drop one lru entry per put
      slot = (occupancy > cap) ? oldest_slot() : -1;
      if (slot >= 0) begin
        live[slot]     = 1'b0;
        age_rank[slot] = 0;
        occupancy--;
      end
      res.ok = 1'b1;
    end else begin
      if (occupancy >= cap) begin
        // full: reuse the lru slot for the new key
        slot = oldest_slot();
        if (slot >= 0) make_recent(slot);
      end else begin
        for (int i = DEPTH - 1; i >= 0; i--)
          if (!live[i]) slot = i;
        for (int i = 0; i < DEPTH; i++)
          if (live[i]) age_rank[i]++;
        live[slot]     = 1'b1;
        age_rank[slot] = 0;
        occupancy++;
      end
      if (slot >= 0) begin
        held_key[slot]   = item.lookup_key;
        held_value[slot] = item.write_value;
      end
      res.ok = 1'b1;
    end
    return res;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic command,
                                  input logic [KEY_W-1:0] key, input logic [VALUE_W-1:0] value,
                                  input logic typed = 1'b0, input logic want_ok = 1'b0,
                                  input logic [VALUE_W-1:0] want_value = '0);
    dir_row_t row;
    row.kind            = kind;
    row.command         = command;
    row.key             = key;
    row.value           = value;
    row.typed           = typed;
    row.want.ok         = want_ok;
    row.want.read_value = want_value;
    directed_rows.push_back(row);
  endfunction

  function automatic void note_fault(input string what, input rsp_t want, input rsp_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch on %s at %0t: expected ok=%0b value=%h, got ok=%0b value=%h",
               what, $realtime, want.ok, want.read_value, got.ok, got.read_value);
  endfunction

  task automatic send_request(input req_t item, input logic typed, input rsp_t want);
    rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= item;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = apply_request(item);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // only written with the cache drained
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we   <= 1'b0;
    capacity = cap;
  endtask

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        note_fault("unexpected item", '0, rsp.data);
      end else begin
        want = pending_results.pop_front();
        if (rsp.data.ok !== want.ok) note_fault("ok", want, rsp.data);
        if (rsp.data.read_value !== want.read_value) note_fault("read_value", want, rsp.data);
      end
    end
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : stimulus
    req_t             item;
    logic [CAP_W-1:0] cap;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req.valid      = 1'b0;
    req.data       = '0;
    fault_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    occupancy      = 0;
    capacity       = CAP_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      live[i]       = 1'b0;
      age_rank[i]   = 0;
      held_key[i]   = '0;
      held_value[i] = '0;
    end

    add_row(ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
    add_row(ROW_REQ, CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0);
    add_row(ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    add_row(ROW_REQ, CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0);
    add_row(ROW_REQ, CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0);
    add_row(ROW_REQ, CMD_PUT, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0);
    add_row(ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678);
    add_row(ROW_REQ, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
    add_row(ROW_REQ, CMD_PUT, 32'h0000_0000, 32'hA5A5_A5A5, 1'b1, 1'b1, 32'h0);
    // zero capacity acts as one, three entries held
    add_row(ROW_CAP, CMD_GET, '0, 32'd0);
    add_row(ROW_REQ, CMD_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
    add_row(ROW_REQ, CMD_PUT, 32'h0000_0001, 32'h0000_0001);
    add_row(ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000);
    add_row(ROW_REQ, CMD_GET, 32'h0000_0001, 32'h0000_0000);
    // above depth acts as depth
    add_row(ROW_CAP, CMD_GET, '0, 32'd31);
    add_row(ROW_REQ, CMD_PUT, 32'h0000_0002, 32'h0000_0002);
    add_row(ROW_REQ, CMD_PUT, 32'h0000_0003, 32'h0000_0003);
    add_row(ROW_REQ, CMD_PUT, 32'h0000_0004, 32'h0000_0004);
    add_row(ROW_CAP, CMD_GET, '0, 32'd2);
    add_row(ROW_REQ, CMD_PUT, 32'h0000_0005, 32'h0000_0005);
    add_row(ROW_REQ, CMD_PUT, 32'h0000_0003, 32'h0000_0033);
    add_row(ROW_REQ, CMD_GET, 32'h0000_0002, 32'h0000_0000);
    add_row(ROW_REQ, CMD_GET, 32'h0000_0004, 32'h0000_0000);
    add_row(ROW_REQ, CMD_GET, 32'h0000_0003, 32'h0000_0000);
    add_row(ROW_CAP, CMD_GET, '0, 32'd16);
    add_row(ROW_REQ, CMD_GET, 32'h0000_0005, 32'h0000_0000);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_CAP) begin
        write_capacity(directed_rows[n].value[CAP_W-1:0]);
      end else begin
        item.command     = directed_rows[n].command;
        item.lookup_key  = directed_rows[n].key;
        item.write_value = directed_rows[n].value;
        send_request(item, directed_rows[n].typed, directed_rows[n].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: cap = 5'd1;
        1: cap = 5'd16;
        2: cap = 5'd0;
        3: cap = 5'd31;
        6: cap = 5'd4;
        7: cap = 5'd8;
        default: cap = CAP_W'($urandom_range(31));
      endcase
      write_capacity(cap);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      // a small pool slightly larger than the table keeps hits and evictions frequent
      foreach (key_pool[i]) key_pool[i] = $urandom;
      repeat (PHASE_ITEMS) begin
        item.command     = $urandom_range(1) ? CMD_PUT : CMD_GET;
        item.lookup_key  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL - 1)]
                                                     : $urandom;
        item.write_value = $urandom;
        send_request(item, 1'b0, '0);
      end
    end

    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #500000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
rtl/lkv_pkg.sv
rtl/lkv_req_if.sv
rtl/lkv_rsp_if.sv
rtl/lru_key_value_cache.sv
test/testbench.sv
